FILE: hw/rtl/nvc_pkg.sv
// ----------------------------------------------------------------------------
// nvc_pkg: shared types and constants of the volume compositor
// Item structs, datapath commands, fixed-point constants and the 2^x helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nvc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 1'd1;

  localparam logic [15:0] STEP_SIZE_RESET      = 16'd111;
  localparam logic [15:0] STOP_THRESHOLD_RESET = 16'd64881;  // 0.99

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [21:0] X_CAP     = 22'h20_0000;           // 32.0 in Q16
  localparam logic [16:0] ONE_Q16   = 17'h1_0000;

  // round(65536 * 2^(i/16))
  localparam logic [17:0] POW2_TABLE [17] = '{
    18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
    18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic        [15:0] ray_index;
    logic signed [15:0] density_raw;
    logic signed [15:0] red_raw;
    logic signed [15:0] green_raw;
    logic signed [15:0] blue_raw;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ray_out;
    logic [15:0] opacity_sum;
    logic [15:0] red_sum;
    logic [15:0] green_sum;
    logic [15:0] blue_sum;
    logic        terminated;
  } out_item_t;

  // One store entry
  typedef struct packed {
    logic [15:0] opacity;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } accum_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,     // zero one store entry
    OP_LOAD,      // capture input item, start index reduction
    OP_MOD,       // one step of index reduction
    OP_READ,      // issue store read
    OP_FETCH,     // capture store entry
    OP_LOGSCALE,  // tz = |raw| * log2(e)
    OP_POWD,      // density exponent: 2^-tz or 2^frac(tz)
    OP_SCALE,     // p = ev * step
    OP_XLOG,      // shift/cap x, tz = x * log2(e)
    OP_EXP,       // ev = 2^-tz, divider init
    OP_WEIGHT,    // weight and new opacity
    OP_DIV,       // one quotient bit
    OP_ACC,       // colour accumulate
    OP_WRITE      // write back, load result register
  } op_t;

  typedef enum logic [1:0] {
    CH_DENSITY,
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef struct packed {
    op_t   op;
    chan_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic div_last;
  } dp_status_t;

  // 2^(f/65536) in Q16, linear interpolation between table points
  function automatic logic [17:0] pow2_frac(input logic [15:0] f);
    logic [3:0]  i;
    logic [11:0] r;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [12:0] dlt;
    logic [24:0] pr;
    i   = f[15:12];
    r   = f[11:0];
    lo  = POW2_TABLE[i];
    hi  = POW2_TABLE[5'(i) + 5'd1];
    dlt = 13'(hi - lo);
    pr  = dlt * r;
    return lo + 18'(pr[24:12]);
  endfunction

  // 2^(-z/65536) in Q16, result in [0, 65536]
  function automatic logic [16:0] neg_exp2(input logic [23:0] z);
    logic [7:0]  n;
    logic [15:0] g;
    logic [17:0] pf;
    logic [16:0] base;
    n    = z[23:16];
    g    = z[15:0];
    pf   = pow2_frac(16'(ONE_Q16 - {1'b0, g}));
    base = (g == 16'd0) ? ONE_Q16 : pf[17:1];
    if (n >= 8'd17) begin
      return '0;
    end
    return base >> n[4:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nvc_ram.sv
// ----------------------------------------------------------------------------
// nvc_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nvc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nvc_datapath.sv
// ----------------------------------------------------------------------------
// nvc_datapath: compositing arithmetic
// Shared exp/multiply unit, radix-2 divider, index reduction, store access.
// ----------------------------------------------------------------------------
`default_nettype none

module nvc_datapath import nvc_pkg::*; #(
  parameter int RAY_COUNT = 65536
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire in_item_t               in_data,
  output out_item_t                   out_data,
  output logic                        ram_we,
  output logic [(RAY_COUNT > 1 ? $clog2(RAY_COUNT) : 1)-1:0] ram_waddr,
  output accum_t                      ram_wdata,
  output logic                        ram_re,
  output logic [(RAY_COUNT > 1 ? $clog2(RAY_COUNT) : 1)-1:0] ram_raddr,
  input  wire accum_t                 ram_rdata
);

  localparam int IDX_W = RAY_COUNT > 1 ? $clog2(RAY_COUNT) : 1;
  localparam bit MOD_DIRECT = (RAY_COUNT >= 65536) || ((RAY_COUNT & (RAY_COUNT - 1)) == 0);
  // ray / RAY_COUNT = (ray * ceil(2^MOD_S / RAY_COUNT)) >> MOD_S, exact for 16-bit rays
  localparam int     MOD_S      = 16 + IDX_W;
  localparam longint MOD_M_FULL = MOD_DIRECT ? longint'(0) :
    ((longint'(1) << MOD_S) + longint'(RAY_COUNT) - longint'(1)) / longint'(RAY_COUNT);
  localparam logic [17:0]      MOD_M    = 18'(MOD_M_FULL);
  localparam logic [15:0]      MOD_C    = 16'(RAY_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAY_COUNT - 1);

  logic [15:0]      step;
  logic [15:0]      thr;
  in_item_t         item;
  logic [15:0]      mq;
  logic [15:0]      mr;
  logic             mph;
  logic [IDX_W-1:0] clr_cnt;
  logic [IDX_W-1:0] idx;
  logic [15:0]      opa;
  logic [15:0]      sums [3];
  logic [23:0]      tz;
  logic [17:0]      ev;
  logic [7:0]       k;
  logic             neg;
  logic [33:0]      p;
  logic [16:0]      weight;
  logic [18:0]      rem;
  logic [16:0]      q;
  logic [4:0]       dcnt;

  // combinational helpers
  logic signed [15:0] raw_sel;
  logic [16:0]      mag;
  logic [33:0]      ls_prod;
  logic [53:0]      x_wide;
  logic [21:0]      x_val;
  logic [38:0]      x_prod;
  logic [16:0]      alpha;
  logic [33:0]      w_prod;
  logic [17:0]      opa_sum;
  logic [17:0]      div_d;
  logic             div_ge;
  logic [18:0]      div_r;
  logic [16:0]      sig;
  logic [33:0]      c_prod;
  logic [1:0]       ch;
  logic [17:0]      c_sum;
  logic [33:0]      mq_prod;
  logic [31:0]      mr_prod;

  always_comb begin
    case (cmd.sel)
      CH_DENSITY: raw_sel = item.density_raw;
      CH_RED:     raw_sel = item.red_raw;
      CH_GREEN:   raw_sel = item.green_raw;
      CH_BLUE:    raw_sel = item.blue_raw;
      default:    raw_sel = item.density_raw;
    endcase
  end

  assign mag     = raw_sel[15] ? 17'(ONE_Q16 - {1'b0, raw_sel}) : {1'b0, raw_sel};
  assign ls_prod = mag * LOG2E_Q16;

  always_comb begin
    x_wide = 54'(p) << k[4:0];
    if (neg) begin
      x_val = {6'd0, p[31:16]};
    end else if (k >= 8'd21 || x_wide[53:16] > 38'(X_CAP)) begin
      x_val = X_CAP;
    end else begin
      x_val = x_wide[37:16];
    end
  end
  assign x_prod = x_val * LOG2E_Q16;

  assign alpha   = (step == 16'd0) ? 17'd0 : 17'(ONE_Q16 - ev[16:0]);
  assign w_prod  = alpha * 17'(ONE_Q16 - {1'b0, opa});
  assign opa_sum = {2'b0, opa} + {1'b0, w_prod[32:16]};

  assign div_d  = 18'(ONE_Q16) + {1'b0, ev[16:0]};
  assign div_ge = rem >= {1'b0, div_d};
  assign div_r  = div_ge ? (rem - {1'b0, div_d}) : rem;

  assign sig    = neg ? 17'(ONE_Q16 - q) : q;
  assign c_prod = weight * sig;
  assign ch     = 2'(cmd.sel) - 2'd1;
  assign c_sum  = {2'b0, sums[ch]} + {1'b0, c_prod[32:16]};

  // index reduction: quotient by reciprocal, then remainder
  assign mq_prod = item.ray_index * MOD_M;
  assign mr_prod = mq * MOD_C;

  always_comb begin
    if (RAY_COUNT == 1) begin
      idx = '0;
    end else if (MOD_DIRECT) begin
      idx = IDX_W'(item.ray_index);
    end else begin
      idx = IDX_W'(mr);
    end
  end

  assign status.clr_last = clr_cnt == LAST_IDX;
  assign status.mod_last = MOD_DIRECT || mph;
  assign status.div_last = dcnt == 5'd0;

  // Store port
  assign ram_re    = cmd.op == OP_READ;
  assign ram_raddr = idx;
  assign ram_we    = cmd.op == OP_CLEAR || cmd.op == OP_WRITE;
  assign ram_waddr = (cmd.op == OP_CLEAR) ? clr_cnt : idx;
  always_comb begin
    if (cmd.op == OP_CLEAR) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = '{opacity: opa, red: sums[0], green: sums[1], blue: sums[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_SIZE_RESET;
      thr     <= STOP_THRESHOLD_RESET;
      clr_cnt <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_STEP_SIZE) begin
        step <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_STOP_THRESHOLD) begin
        thr <= cfg_data;
      end
      if (cmd.op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        item <= in_data;
        mph  <= 1'b0;
      end
      OP_MOD: begin
        if (!mph) begin
          mq  <= 16'(mq_prod >> MOD_S);
          mph <= 1'b1;
        end else begin
          mr  <= item.ray_index - mr_prod[15:0];
        end
      end
      OP_FETCH: begin
        opa     <= ram_rdata.opacity;
        sums[0] <= ram_rdata.red;
        sums[1] <= ram_rdata.green;
        sums[2] <= ram_rdata.blue;
      end
      OP_LOGSCALE: begin
        tz  <= ls_prod[31:8];
        neg <= raw_sel[15];
      end
      OP_POWD: begin
        ev <= neg ? {1'b0, neg_exp2(tz)} : pow2_frac(tz[15:0]);
        k  <= tz[23:16];
      end
      OP_SCALE: begin
        p <= ev * step;
      end
      OP_XLOG: begin
        tz <= {2'b0, x_prod[37:16]};
      end
      OP_EXP: begin
        ev   <= {1'b0, neg_exp2(tz)};
        rem  <= 19'(ONE_Q16);
        q    <= '0;
        dcnt <= 5'd16;
      end
      OP_WEIGHT: begin
        weight <= w_prod[32:16];
        opa    <= (opa_sum > 18'd65535) ? 16'hFFFF : opa_sum[15:0];
      end
      OP_DIV: begin
        rem  <= {div_r[17:0], 1'b0};
        q    <= {q[15:0], div_ge};
        dcnt <= dcnt - 5'd1;
      end
      OP_ACC: begin
        sums[ch] <= (c_sum > 18'd65535) ? 16'hFFFF : c_sum[15:0];
      end
      OP_WRITE: begin
        out_data <= '{ray_out: item.ray_index, opacity_sum: opa, red_sum: sums[0],
                      green_sum: sums[1], blue_sum: sums[2], terminated: opa >= thr};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nvc_ctrl.sv
// ----------------------------------------------------------------------------
// nvc_ctrl: compositor sequencer
// Clearing pass, per-sample command sequence and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module nvc_ctrl import nvc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_READ, S_FETCH, S_DLOG, S_POWD, S_SCALE,
    S_XLOG, S_AEXP, S_WEIGHT, S_CLOG, S_CEXP, S_DIV, S_ACC, S_OUT
  } state_t;

  state_t state;
  chan_t  ch;
  logic   out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.sel = CH_DENSITY;
    case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_MOD:    cmd.op = OP_MOD;
      S_READ:   cmd.op = OP_READ;
      S_FETCH:  cmd.op = OP_FETCH;
      S_DLOG:   cmd.op = OP_LOGSCALE;
      S_POWD:   cmd.op = OP_POWD;
      S_SCALE:  cmd.op = OP_SCALE;
      S_XLOG:   cmd.op = OP_XLOG;
      S_AEXP:   cmd.op = OP_EXP;
      S_WEIGHT: cmd.op = OP_WEIGHT;
      S_CLOG: begin
        cmd.op  = OP_LOGSCALE;
        cmd.sel = ch;
      end
      S_CEXP:   cmd.op = OP_EXP;
      S_DIV:    cmd.op = OP_DIV;
      S_ACC: begin
        cmd.op  = OP_ACC;
        cmd.sel = ch;
      end
      S_OUT:    cmd.op = out_free ? OP_WRITE : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ch        <= CH_RED;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR:  if (status.clr_last) state <= S_IDLE;
        S_IDLE:   if (in_valid) state <= S_MOD;
        S_MOD:    if (status.mod_last) state <= S_READ;
        S_READ:   state <= S_FETCH;
        S_FETCH:  state <= S_DLOG;
        S_DLOG:   state <= S_POWD;
        S_POWD:   state <= S_SCALE;
        S_SCALE:  state <= S_XLOG;
        S_XLOG:   state <= S_AEXP;
        S_AEXP:   state <= S_WEIGHT;
        S_WEIGHT: begin
          ch    <= CH_RED;
          state <= S_CLOG;
        end
        S_CLOG:   state <= S_CEXP;
        S_CEXP:   state <= S_DIV;
        S_DIV:    if (status.div_last) state <= S_ACC;
        S_ACC: begin
          case (ch)
            CH_RED:   ch <= CH_GREEN;
            CH_GREEN: ch <= CH_BLUE;
            default:  ch <= CH_RED;
          endcase
          state <= (ch == CH_BLUE) ? S_OUT : S_CLOG;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result register is never overwritten while its transfer is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_WRITE |-> out_free)
    else $error("result overwritten before transfer");

  // one sample in flight: no second input transfer straight after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  // the last quotient bit leads to the colour accumulate
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && status.div_last |=> state == S_ACC)
    else $error("divider exit missed");

  // a new result only follows a write-back command
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == OP_WRITE))
    else $error("result valid without write-back");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/nerf_volume_compositor_core.sv
// ----------------------------------------------------------------------------
// nerf_volume_compositor_core: front-to-back alpha compositor for ray samples
// Per-ray opacity and RGB accumulation in fixed point with early termination.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the per-ray store, one
// entry per cycle, with in_ready low (configuration writes are taken
// throughout). Each accepted sample then goes through index reduction,
// store read, density and alpha steps, three colour steps and write-back;
// when RAY_COUNT is neither a power of two nor at least 65536, the ray index
// is reduced modulo RAY_COUNT by a reciprocal multiply and then a subtract.
// Write-back waits while an earlier result still sits untransferred in the
// output register. One sample is worked on at a time, through the shared
// exp/multiply unit and the single radix-2 divider that forms the three
// colour sigmoids, each colour with its own log and exp steps. A finished
// result sits in an output register, so the next sample is taken while it
// waits for its transfer.
// alpha = 1 - exp(-exp(density) * step_size), weight = alpha times
// (1 - opacity); opacity and colour sums are Q0.16 and saturate at 65535.
// Rays past the stop threshold keep accumulating; terminated only reports it.
// Registers: index 0 step_size (reset 111), index 1 stop_threshold (64881).
// ----------------------------------------------------------------------------
`default_nettype none

module nerf_volume_compositor_core import nvc_pkg::*; #(
  parameter int RAY_COUNT = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  localparam int IDX_W = RAY_COUNT > 1 ? $clog2(RAY_COUNT) : 1;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  accum_t           ram_wdata;
  accum_t           ram_rdata;

  // sequencer: clearing pass, sample steps, transfer handshakes
  nvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic, config registers, result register
  nvc_datapath #(
    .RAY_COUNT (RAY_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // per-ray store: {opacity, red, green, blue}
  nvc_ram #(
    .WIDTH ($bits(accum_t)),
    .DEPTH (RAY_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: verif/tb_nerf_volume_compositor_core.sv
// ----------------------------------------------------------------------------
// tb_nerf_volume_compositor_core: self-checking bench for the compositor core
// Drives ray samples through valid/ready, predicts the per-ray opacity and
// colour sums in fixed point and compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nerf_volume_compositor_core;
  import nvc_pkg::*;

  localparam int RAYS = 65536;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  nerf_volume_compositor_core #(.RAY_COUNT(RAYS)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state: own copy of the store and registers
  logic [15:0] acc_opa [RAYS];
  logic [15:0] acc_red [RAYS];
  logic [15:0] acc_grn [RAYS];
  logic [15:0] acc_blu [RAYS];
  logic [15:0] march_step;
  logic [15:0] stop_level;

  localparam logic [31:0] EXP_TAB [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682, 96785,
    101070, 105545, 110218, 115098, 120194, 125515, 131072
  };

  in_item_t  sample_q [$];
  out_item_t totals_q [$];
  int        n_err = 0;
  bit        hold_long;   // long receiver hold-off request
  bit        in_fire;     // input transfer on the last rising edge
  bit        out_fire;    // result transfer on the last rising edge

  function automatic logic [63:0] exp2_frac(logic [63:0] f);
    logic [63:0] lo;
    logic [63:0] hi;
    lo = EXP_TAB[f[15:12]];
    hi = EXP_TAB[f[15:12] + 1];
    return lo + (((hi - lo) * f[11:0]) >> 12);
  endfunction

  function automatic logic [63:0] exp2_neg(logic [63:0] z);
    logic [63:0] n;
    logic [63:0] g;
    logic [63:0] b;
    n = z >> 16;
    g = z & 64'hFFFF;
    if (n >= 17) return 0;
    b = (g == 0) ? 64'd65536 : (exp2_frac(65536 - g) >> 1);
    return b >> n;
  endfunction

  function automatic logic [63:0] alpha_from(logic [15:0] d);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] p;
    if (march_step == 0) return 0;
    if (d[15]) begin
      t = exp2_neg(((65536 - {48'd0, d}) * 94548) >> 8);
      x = (t * march_step) >> 16;
    end else begin
      t = ({48'd0, d} * 94548) >> 8;
      p = exp2_frac(t & 64'hFFFF) * march_step;
      if ((t >> 16) >= 21) x = 64'd2097152;
      else x = (p << (t >> 16)) >> 16;
    end
    if (x > 64'd2097152) x = 64'd2097152;
    return 65536 - exp2_neg((x * 94548) >> 16);
  endfunction

  function automatic logic [63:0] squash(logic [15:0] c);
    logic [63:0] m;
    logic [63:0] s;
    m = c[15] ? (65536 - {48'd0, c}) : {48'd0, c};
    s = (64'd1 << 32) / (65536 + exp2_neg((m * 94548) >> 8));
    return c[15] ? (65536 - s) : s;
  endfunction

  function automatic logic [15:0] sat16(logic [63:0] a, logic [63:0] b);
    return (a + b > 65535) ? 16'hFFFF : 16'(a + b);
  endfunction

  task automatic queue_sample(in_item_t s);
    sample_q = {sample_q, s};
  endtask

  // Composite one sample into the predictor store and queue its totals
  task automatic composite_sample(in_item_t s);
    logic [15:0] r;
    logic [63:0] w;
    out_item_t o;
    r = s.ray_index;
    w = (alpha_from(s.density_raw) * (65536 - acc_opa[r])) >> 16;
    acc_opa[r] = sat16(acc_opa[r], w);
    acc_red[r] = sat16(acc_red[r], (w * squash(s.red_raw)) >> 16);
    acc_grn[r] = sat16(acc_grn[r], (w * squash(s.green_raw)) >> 16);
    acc_blu[r] = sat16(acc_blu[r], (w * squash(s.blue_raw)) >> 16);
    o.ray_out = s.ray_index;
    o.opacity_sum = acc_opa[r];
    o.red_sum = acc_red[r];
    o.green_sum = acc_grn[r];
    o.blue_sum = acc_blu[r];
    o.terminated = acc_opa[r] >= stop_level;
    totals_q = {totals_q, o};
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Time limit for the clearing pass and ~1700 samples
  initial begin
    #4000000;
    $display("FAIL nerf_volume_compositor_core");
    $finish;
  end

  // Transfers seen at the rising edge, used by the falling-edge processes
  always @(posedge clk) begin
    in_fire  <= !rst && in_valid && in_ready;
    out_fire <= !rst && out_valid && out_ready;
  end

  // Driver: presents queued samples, random gap before each
  int gap_in;
  initial gap_in = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      // transfer took place on the last rising edge
      composite_sample(in_data);
      gap_in = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap_in == 0 && sample_q.size() != 0) begin
        in_data <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_in > 0) gap_in--;
      else if (sample_q.size() != 0) begin
        in_data <= sample_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  int gap_out;
  initial gap_out = 0;
  always @(negedge clk) begin
    if (rst || hold_long) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire)
        gap_out = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap_out > 0) begin
        gap_out--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (totals_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        out_item_t e;
        e = totals_q.pop_front();
        if (e !== out_data) begin
          n_err++;
          if (n_err <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_STEP_SIZE) march_step = v;
    else stop_level = v;
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || totals_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [15:0] r, logic [15:0] d, logic [15:0] cr,
                                  logic [15:0] cg, logic [15:0] cb);
    in_item_t s;
    s.ray_index = r;
    s.density_raw = d;
    s.red_raw = cr;
    s.green_raw = cg;
    s.blue_raw = cb;
    return s;
  endfunction

  // Mostly a few hot rays so opacity builds up and saturates
  function automatic in_item_t rand_sample();
    logic [15:0] r;
    logic [15:0] d;
    r = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    case ($urandom_range(0, 3))
      0: d = 16'($urandom);
      1: d = 16'($signed($urandom_range(0, 1536)) - 768);
      2: d = 16'($urandom_range(0, 2048));
      default: d = 16'($urandom_range(0, 512));
    endcase
    return mk(r, d, 16'($urandom), 16'($urandom_range(0, 3072) - 1536),
              16'($urandom));
  endfunction

  int phase;
  initial begin
    hold_long = 0;
    foreach (acc_opa[i]) begin
      acc_opa[i] = 0; acc_red[i] = 0; acc_grn[i] = 0; acc_blu[i] = 0;
    end
    march_step = STEP_SIZE_RESET;
    stop_level = STOP_THRESHOLD_RESET;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes at reset settings, then zero step, big density
    queue_sample(mk(16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000));
    queue_sample(mk(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
    queue_sample(mk(16'hFFFF, 16'h7FFF, 16'h0100, 16'hFF00, 16'h0001));
    queue_sample(mk(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    queue_sample(mk(16'h0001, 16'h0400, 16'h5555, 16'hAAAA, 16'h1234));
    queue_sample(mk(16'h0001, 16'h0800, 16'h0200, 16'h0300, 16'h0400));
    queue_sample(mk(16'h0001, 16'h0C00, 16'h0200, 16'h0300, 16'h0400));
    queue_sample(mk(16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8001));
    wait_idle();
    write_reg(REG_STEP_SIZE, 16'd0);       // zero step: entries unchanged
    write_reg(REG_STOP_THRESHOLD, 16'd0);  // every sample reports terminated
    queue_sample(mk(16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    queue_sample(mk(16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    wait_idle();
    write_reg(REG_STEP_SIZE, 16'hFFFF);
    write_reg(REG_STOP_THRESHOLD, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      queue_sample(mk(16'h0003, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    wait_idle();

    // Random phases over several register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_STEP_SIZE, STEP_SIZE_RESET);
                 write_reg(REG_STOP_THRESHOLD, STOP_THRESHOLD_RESET); end
        1: begin write_reg(REG_STEP_SIZE, 16'hFFFF);
                 write_reg(REG_STOP_THRESHOLD, 16'h8000); end
        2: begin write_reg(REG_STEP_SIZE, 16'd1);
                 write_reg(REG_STOP_THRESHOLD, 16'd0); end
        default: begin write_reg(REG_STEP_SIZE, 16'($urandom));
                       write_reg(REG_STOP_THRESHOLD, 16'($urandom)); end
      endcase
      for (int i = 0; i < 270; i++) queue_sample(rand_sample());
      if (phase == 1) begin
        // long hold-off: result register fills, input stalls
        @(negedge clk);
        hold_long = 1'b1;
        repeat (600) @(posedge clk);
        @(negedge clk);
        hold_long = 1'b0;
      end
      wait_idle();
    end
    if (n_err == 0) $display("PASS nerf_volume_compositor_core");
    else $display("FAIL nerf_volume_compositor_core");
    $finish;
  end

endmodule

`default_nettype wire
